// File: design/pcc_pkg.sv
// Package for the pileup consensus caller: request/result types and codes.
// No dependencies; used by every module of the block but pcc_ram.
package pcc_pkg;

    localparam int REQ_W   = 2;
    localparam int POS_W   = 16;
    localparam int BASE_W  = 3;
    localparam int ACT_W   = 2;
    localparam int DEPTH_W = 32;
    localparam int MIND_W  = 16;
    localparam int FRAC_W  = 17;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_ADD_BASE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_DEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CALL     = 2'd2;

    localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SUBST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP  = 2'd2;

    localparam logic [BASE_W-1:0] BASE_UNKNOWN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRACTION = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [BASE_W-1:0] read_base;
        logic [BASE_W-1:0] ref_base;
    } req_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [BASE_W-1:0]  out_base;
        logic [DEPTH_W-1:0] column_depth;
    } res_t;

    // Classified command handed from front to back.
    typedef struct packed {
        logic              is_call;
        logic              in_window;
        logic              is_del;
        logic              base_ok;
        logic [1:0]        base;
        logic [POS_W-1:0]  position;
        logic [BASE_W-1:0] ref_base;
    } cmd_t;

endpackage

// File: design/pcc_ram.sv
// Generic RAM with separate write and read ports: one write and one registered read per cycle.
// No dependencies.
module pcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/pcc_front.sv
// Front end: accepts requests, classifies them and pushes commands into a queue.
// Depends on pcc_pkg.
module pcc_front #(
    parameter int COLUMNS = 65536,
    parameter int QDEPTH  = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pcc_pkg::req_t  in_data,
    output logic           cmd_valid,
    input  logic           cmd_pop,
    output pcc_pkg::cmd_t  cmd
);
    import pcc_pkg::*;

    localparam int QA_W = $clog2(QDEPTH);

    cmd_t                q_reg [QDEPTH];
    logic [QA_W-1:0]     wp_reg, rp_reg;
    logic [QA_W:0]       cnt_reg;
    cmd_t                c;
    logic                push, keep;

    always_comb
    begin
        c = '0;
        c.is_call   = (in_data.req_type == REQ_CALL);
        c.is_del    = (in_data.req_type == REQ_ADD_DEL);
        c.in_window = ({8'd0, in_data.position} < 24'(COLUMNS)) ||
                      (COLUMNS > 65535);
        c.base_ok   = (in_data.read_base < 3'd4);
        c.base      = in_data.read_base[1:0];
        c.position  = in_data.position;
        c.ref_base  = (in_data.ref_base > BASE_UNKNOWN) ? BASE_UNKNOWN : in_data.ref_base;
        // Adds outside the window and unused request codes are absorbed here.
        keep = c.is_call || (c.in_window && (in_data.req_type == REQ_ADD_BASE || c.is_del));
    end

    assign in_stall  = (cnt_reg == (QA_W+1)'(QDEPTH));
    assign push      = in_valid && !in_stall && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QA_W+1)'(push) - (QA_W+1)'(cmd_pop);
        end
    end
endmodule

// File: design/pcc_back.sv
// Back end: clears the column store, performs counter updates and column calls.
// Depends on pcc_pkg and pcc_ram.
module pcc_back #(
    parameter int COLUMNS    = 65536,
    parameter int COUNT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    input  pcc_pkg::cmd_t               cmd,
    input  logic [pcc_pkg::MIND_W-1:0]  min_depth,
    input  logic [pcc_pkg::FRAC_W-1:0]  min_fraction,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pcc_pkg::res_t               out_data
);
    import pcc_pkg::*;

    localparam int AW = $clog2(COLUMNS);
    localparam int CW = COUNT_BITS;
    localparam int RW = 6 * CW;
    localparam logic [CW-1:0] TOP = {CW{1'b1}};

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_UPDATE, S_DEL, S_BASE, S_OUT
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   addr_reg;
    cmd_t            cmd_reg;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [RW-1:0]   ram_wdata, ram_rdata;
    logic [CW-1:0]   cnt [6];
    logic [CW-1:0]   upd [6];
    logic [CW-1:0]   dep_reg, top_reg;
    logic [1:0]      win_reg;
    logic            any_reg;
    logic [CW+15:0]  lhs_reg;
    logic [CW+16:0]  rhs_reg;
    logic            reach;
    logic            deep_enough;
    logic [CW-1:0]   top_c;
    logic [1:0]      win_c;
    logic            any_c;
    res_t            res_reg;
    logic            out_valid_reg;

    // Row layout: A, C, G, T, deletion, depth counters.
    pcc_ram #(.WIDTH(RW), .DEPTH(COLUMNS)) u_store (
        .clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(ram_wdata),
        .raddr(ram_addr), .rdata(ram_rdata)
    );

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            cnt[i] = ram_rdata[i*CW +: CW];
            upd[i] = cnt[i];
        end
        if (cmd_reg.is_del)
        begin
            upd[4] = (cnt[4] == TOP) ? TOP : cnt[4] + 1'b1;
        end
        else if (cmd_reg.base_ok)
        begin
            upd[cmd_reg.base] = (cnt[cmd_reg.base] == TOP) ? TOP : cnt[cmd_reg.base] + 1'b1;
        end
        upd[5] = (cnt[5] == TOP) ? TOP : cnt[5] + 1'b1;

        top_c = '0;
        win_c = '0;
        any_c = 1'b0;
        for (int b = 0; b < 4; b++)
        begin
            if (cnt[b] > top_c)
            begin
                top_c = cnt[b];
                win_c = 2'(b);
                any_c = 1'b1;
            end
        end

        ram_we    = 1'b0;
        ram_addr  = AW'(cmd_reg.position);
        ram_wdata = {upd[5], upd[4], upd[3], upd[2], upd[1], upd[0]};
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_UPDATE)
        begin
            ram_we = 1'b1;
        end
        reach       = (lhs_reg >= rhs_reg[CW+15:0]) && !rhs_reg[CW+16];
        deep_enough = (dep_reg != '0) && (DEPTH_W'(dep_reg) >= DEPTH_W'(min_depth));
        cmd_pop     = (state_reg == S_IDLE) && cmd_valid && !out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEL)
        begin
            // Deletion share, taken straight from the row on the read port.
            lhs_reg <= {cnt[4], 16'd0};
            rhs_reg <= min_fraction * cnt[5];
        end
        else
        begin
            // Winning base share, used in the result state.
            lhs_reg <= {top_reg, 16'd0};
            rhs_reg <= min_fraction * dep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            res_reg       <= '0;
            dep_reg       <= '0;
            top_reg       <= '0;
            win_reg       <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(COLUMNS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= cmd_reg.is_call ? S_DEL : S_UPDATE;
                end
                S_UPDATE:
                begin
                    state_reg <= S_IDLE;
                end
                S_DEL:
                begin
                    // Row data still on the read port; capture it.
                    dep_reg   <= cmd_reg.in_window ? cnt[5] : '0;
                    top_reg   <= top_c;
                    win_reg   <= win_c;
                    any_reg   <= any_c && cmd_reg.in_window;
                    state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    res_reg.column_depth <= DEPTH_W'(dep_reg);
                    if (deep_enough && reach)
                    begin
                        res_reg.action   <= ACT_DROP;
                        res_reg.out_base <= '0;
                        state_reg        <= S_IDLE;
                        out_valid_reg    <= 1'b1;
                    end
                    else
                    begin
                        res_reg.action   <= ACT_KEEP;
                        res_reg.out_base <= cmd_reg.ref_base;
                        state_reg        <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (deep_enough && any_reg && reach &&
                        {1'b0, win_reg} != cmd_reg.ref_base)
                    begin
                        res_reg.action   <= ACT_SUBST;
                        res_reg.out_base <= {1'b0, win_reg};
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: design/pileup_consensus_caller_core.sv
// Pileup consensus caller, top level: configuration registers, front and back.
// Depends on pcc_pkg, pcc_front and pcc_back.
//
// Keeps A/C/G/T, deletion and depth counters per column in one memory row and
// answers call requests with keep, substitute or drop. After reset a clearing
// pass writes every row once, during which the front queue fills and then
// stalls. An add passes the back end states take from the queue, read and
// write back; a call passes take, read, capture with the deletion share
// multiply, drop decision with the base share multiply, and result, but
// ends at the drop decision when the column is dropped. The single port of
// the column memory and these registered multiplies set that order. A short
// command queue lets the front keep taking transfers while the back works,
// and the result register holds a call result until the consumer takes it;
// the back end takes no new command while a result waits.
module pileup_consensus_caller_core #(
    parameter int COLUMNS    = 65536,
    parameter int COUNT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  pcc_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output pcc_pkg::res_t                  out_data,
    input  logic                           cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcc_pkg::CFG_W-1:0]      cfg_data
);
    import pcc_pkg::*;

    logic [MIND_W-1:0] min_depth_reg;
    logic [FRAC_W-1:0] min_fraction_reg;
    logic              cmd_valid, cmd_pop;
    cmd_t              cmd;

    // Configuration writes land at once; the user must make them only while idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg    <= 16'd3;
            min_fraction_reg <= 17'd52429;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_DEPTH:    min_depth_reg    <= cfg_data[MIND_W-1:0];
                CFG_MIN_FRACTION: min_fraction_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    pcc_front #(.COLUMNS(COLUMNS), .QDEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
    );

    pcc_back #(.COLUMNS(COLUMNS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
        .min_depth(min_depth_reg), .min_fraction(min_fraction_reg),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

// File: design/pcc_checker.sv
// Port-level checker for the pileup consensus caller, with its bind.
// Depends on pcc_pkg.
module pcc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input pcc_pkg::res_t  out_data
);
    import pcc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.action == ACT_KEEP || out_data.action == ACT_SUBST ||
                      out_data.action == ACT_DROP)
        else $error("bad action code");

    a_drop_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ACT_DROP |-> out_data.out_base == '0)
        else $error("dropped column with nonzero base");

    a_subst_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ACT_SUBST |->
            out_data.out_base < 3'd4 && out_data.column_depth != '0)
        else $error("substitution without a base or depth");
endmodule

bind pileup_consensus_caller_core pcc_checker u_pcc_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: verif/pileup_consensus_caller_core_tb.sv
// Testbench for pileup_consensus_caller_core: directed and random transfers,
// checked against a predictor kept in this file. Depends on pcc_pkg and the RTL.
`timescale 1ns / 1ps

module pileup_consensus_caller_core_tb;
    import pcc_pkg::*;

    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
    // Adds give no result, so after the last call result the back end may
    // still be busy with queued adds; this settle time covers the whole queue.
    localparam int SETTLE_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    res_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_DEPTH;
    logic [CFG_W-1:0] cfg_data = '0;

    pileup_consensus_caller_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Pileup mirror: sparse, keyed by column (and column*4+base for bases).
    logic [31:0] base_tally[int];
    logic [31:0] del_tally[int];
    logic [31:0] depth_tally[int];
    logic [15:0] depth_floor = 16'd3;
    logic [16:0] share_floor = 17'd52429;

    res_t expected_calls[$];
    int failures = 0;
    int burst_left = 4;
    int hold_cycles = 0;
    logic [15:0] column_pool[6] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                    16'h8000, 16'hFFFF};

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [31:0] tally(ref logic [31:0] arr[int], input int key);
        return arr.exists(key) ? arr[key] : 32'd0;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == COUNT_TOP) ? v : v + 32'd1;
    endfunction

    // Share test done exactly: count * 65536 >= share_floor * depth.
    function automatic bit share_met(input logic [31:0] num, input logic [31:0] den);
        logic [63:0] lhs;
        logic [63:0] rhs;
        lhs = {16'd0, num, 16'd0};
        rhs = 64'(share_floor) * 64'(den);
        return lhs >= rhs;
    endfunction

    // Applies one accepted request to the mirror; for a call, queues the result.
    task automatic apply_request(input req_t r);
        int col;
        logic [31:0] dep;
        logic [31:0] top;
        logic [31:0] cnt;
        logic [BASE_W-1:0] refb;
        logic [BASE_W-1:0] winner;
        bit seen;
        res_t res;
        col = int'(r.position);
        if (r.req_type == REQ_ADD_BASE || r.req_type == REQ_ADD_DEL)
        begin
            if (r.req_type == REQ_ADD_DEL)
                del_tally[col] = bump(tally(del_tally, col));
            else if (r.read_base < BASE_UNKNOWN)
                base_tally[col*4 + int'(r.read_base)] =
                    bump(tally(base_tally, col*4 + int'(r.read_base)));
            depth_tally[col] = bump(tally(depth_tally, col));
        end
        else if (r.req_type == REQ_CALL)
        begin
            refb = (r.ref_base > BASE_UNKNOWN) ? BASE_UNKNOWN : r.ref_base;
            dep = tally(depth_tally, col);
            res.action = ACT_KEEP;
            res.out_base = refb;
            res.column_depth = dep;
            if (dep != 0 && dep >= 32'(depth_floor))
            begin
                if (share_met(tally(del_tally, col), dep))
                begin
                    res.action = ACT_DROP;
                    res.out_base = BASE_A;
                end
                else
                begin
                    // Strictly greater wins, so ties stay with the lower code.
                    top = 0;
                    seen = 0;
                    winner = BASE_A;
                    for (int b = 0; b < 4; b++)
                    begin
                        cnt = tally(base_tally, col*4 + b);
                        if (cnt > top)
                        begin
                            top = cnt;
                            winner = BASE_W'(b);
                            seen = 1;
                        end
                    end
                    if (seen && share_met(top, dep) && winner != refb)
                    begin
                        res.action = ACT_SUBST;
                        res.out_base = winner;
                    end
                end
            end
            expected_calls = {expected_calls, res};
        end
    endtask

    // Offers one transfer and holds it until accepted. Valid stays high for
    // the next item of a burst; a burst ends with a random gap.
    task automatic send_request(input req_t r);
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_fields(input logic [REQ_W-1:0] kind, input logic [15:0] pos,
                               input logic [BASE_W-1:0] rb, input logic [BASE_W-1:0] refb);
        req_t r;
        r.req_type = kind;
        r.position = pos;
        r.read_base = rb;
        r.ref_base = refb;
        send_request(r);
    endtask

    // Sender pauses until every call result has come back and the back end settles.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_calls.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_DEPTH)
            depth_floor = val[15:0];
        else
            share_floor = val;
    endtask

    task automatic set_thresholds(input logic [15:0] dep, input logic [16:0] frac);
        write_config(CFG_MIN_DEPTH, CFG_W'(dep));
        write_config(CFG_MIN_FRACTION, frac);
    endtask

    function automatic req_t random_request();
        req_t r;
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 42) r.req_type = REQ_ADD_BASE;
        else if (pick < 58) r.req_type = REQ_ADD_DEL;
        else if (pick < 95) r.req_type = REQ_CALL;
        else r.req_type = REQ_UNUSED;
        k = $urandom_range(0, 5);
        r.position = ($urandom_range(0, 6) == 0) ? 16'($urandom) : column_pool[k];
        // Each pooled column leans toward one base so that calls can substitute.
        r.read_base = ($urandom_range(0, 9) < 6) ? BASE_W'(k % 4) : BASE_W'($urandom_range(0, 7));
        r.ref_base = BASE_W'($urandom_range(0, 7));
        return r;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Receiver: stalls on its own random pattern, with quiet stretches,
    // and honors a long hold-off when one is requested.
    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 80);
            end
            span--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (mode == 0)
                out_stall <= 1'b0;
            else if (mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_calls.size() == 0)
            begin
                $error("unexpected result transfer: action=%0d out_base=%0d depth=%0d",
                       out_data.action, out_data.out_base, out_data.column_depth);
                failures++;
            end
            else
            begin
                want = expected_calls.pop_front();
                if (out_data.action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, out_data.action);
                    failures++;
                end
                if (out_data.out_base !== want.out_base)
                begin
                    $error("out_base: expected %0d, got %0d", want.out_base, out_data.out_base);
                    failures++;
                end
                if (out_data.column_depth !== want.column_depth)
                begin
                    $error("column_depth: expected %0d, got %0d",
                           want.column_depth, out_data.column_depth);
                    failures++;
                end
            end
        end
    end

    // Field extremes, every request kind and each corner of the call logic.
    task automatic test_directed;
        set_thresholds(16'd3, 17'd52429);
        send_fields(REQ_CALL, 16'h0000, BASE_G, BASE_C);      // empty column keeps
        send_fields(REQ_CALL, 16'hFFFF, BASE_A, 3'd7);        // ref above range -> unknown
        repeat (3) send_fields(REQ_ADD_BASE, 16'hFFFF, BASE_T, BASE_A);
        send_fields(REQ_CALL, 16'hFFFF, BASE_A, BASE_A);      // substitute with T
        send_fields(REQ_CALL, 16'hFFFF, BASE_A, BASE_T);      // winner equals reference
        send_fields(REQ_ADD_BASE, 16'h0005, 3'd7, 3'd7);      // other base: depth only
        send_fields(REQ_ADD_BASE, 16'h0005, BASE_UNKNOWN, BASE_A);
        send_fields(REQ_ADD_BASE, 16'h0005, 3'd5, BASE_A);
        send_fields(REQ_CALL, 16'h0005, BASE_A, BASE_C);      // no base seen
        send_fields(REQ_UNUSED, 16'h0005, BASE_A, BASE_A);    // ignored
        repeat (3) send_fields(REQ_ADD_DEL, 16'h0009, BASE_A, BASE_A);
        send_fields(REQ_CALL, 16'h0009, BASE_A, BASE_G);      // dropped column
        send_fields(REQ_ADD_BASE, 16'h000A, BASE_C, BASE_A);
        send_fields(REQ_ADD_BASE, 16'h000A, BASE_G, BASE_A);
        send_fields(REQ_CALL, 16'h000A, BASE_A, BASE_UNKNOWN); // below depth floor
        send_fields(REQ_ADD_BASE, 16'h000A, 3'd6, BASE_A);
        send_fields(REQ_CALL, 16'h000A, BASE_A, BASE_T);      // tie C/G, share too low
        drain();
        set_thresholds(16'd1, 17'd32768);
        send_fields(REQ_CALL, 16'h000A, BASE_A, BASE_T);      // tie goes to C, share still too low
        send_fields(REQ_CALL, 16'hFFFF, BASE_A, BASE_UNKNOWN);
        drain();
    endtask

    // Long receiver hold-off while transfers keep coming, so the block backs up.
    task automatic test_backpressure;
        set_thresholds(16'd2, 17'd45000);
        hold_cycles = 400;
        random_phase(100);
        drain();
    endtask

    // Random traffic across a range of thresholds, extremes included.
    task automatic test_random_settings;
        set_thresholds(16'd1, 17'd0);
        random_phase(70);
        drain();
        set_thresholds(16'd65535, 17'd65536);
        random_phase(60);
        drain();
        set_thresholds(16'd4, 17'd131071);
        random_phase(60);
        drain();
        set_thresholds(16'd1, 17'd65536);
        random_phase(70);
        drain();
        set_thresholds(16'd3, 17'd52429);
        random_phase(80);
        drain();
        set_thresholds(16'd6, 17'd32768);
        random_phase(80);
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_settings();
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
